FILE: sv/lcdw_pkg.sv
package lcdw_pkg;

  // request command codes
  localparam logic [1:0] CMD_INSTR = 2'd0;
  localparam logic [1:0] CMD_CHAR  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;

  // job kinds held in the queue
  localparam logic [1:0] JOB_INSTR = 2'd0;
  localparam logic [1:0] JOB_CHAR  = 2'd1;
  localparam logic [1:0] JOB_INIT  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_WAIT   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_WAIT    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WAKEUP_WAIT  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_SET = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_SETUP  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_CTRL = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_MODE   = 4'd7;

  // register reset values
  localparam logic [7:0] RST_PULSE_WIDTH  = 8'd1;
  localparam logic [7:0] RST_SHORT_WAIT   = 8'd1;
  localparam logic [7:0] RST_LONG_WAIT    = 8'd3;
  localparam logic [7:0] RST_WAKEUP_WAIT  = 8'd10;
  localparam logic [7:0] RST_FUNCTION_SET = 8'h28;
  localparam logic [7:0] RST_SHIFT_SETUP  = 8'h10;
  localparam logic [7:0] RST_DISPLAY_CTRL = 8'h0F;
  localparam logic [7:0] RST_ENTRY_MODE   = 8'h06;

  // instructions below this get the long wait
  localparam logic [7:0] LONG_WAIT_LIMIT = 8'd4;

  localparam logic [3:0] WAKE_NIBBLE = 4'h3;
  localparam logic [3:0] MODE_NIBBLE = 4'h2;

  // wake-up sequence is steps 0..WAKE_LAST, each byte is nibble steps 0..NIB_LAST
  localparam logic [3:0] WAKE_LAST = 4'd10;
  localparam logic [2:0] NIB_LAST  = 3'd4;
  localparam logic [1:0] INIT_BYTE_LAST = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic       enable_pin;
    logic       register_select;
    logic       read_write;
    logic [3:0] bus_nibble;
    logic [7:0] hold_ms;
    logic       last_segment;
  } out_item_t;

  typedef struct packed {
    logic [7:0] pulse_width_ms;
    logic [7:0] short_wait_ms;
    logic [7:0] long_wait_ms;
    logic [7:0] wakeup_wait_ms;
    logic [7:0] function_set_byte;
    logic [7:0] shift_setup_byte;
    logic [7:0] display_control_byte;
    logic [7:0] entry_mode_byte;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       long_settle;
  } job_t;

endpackage

FILE: sv/lcdw_cfg.sv
module lcdw_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lcdw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                         cfg_data,
  output lcdw_pkg::cfg_t                     regs
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pulse_width_ms       <= lcdw_pkg::RST_PULSE_WIDTH;
      regs.short_wait_ms        <= lcdw_pkg::RST_SHORT_WAIT;
      regs.long_wait_ms         <= lcdw_pkg::RST_LONG_WAIT;
      regs.wakeup_wait_ms       <= lcdw_pkg::RST_WAKEUP_WAIT;
      regs.function_set_byte    <= lcdw_pkg::RST_FUNCTION_SET;
      regs.shift_setup_byte     <= lcdw_pkg::RST_SHIFT_SETUP;
      regs.display_control_byte <= lcdw_pkg::RST_DISPLAY_CTRL;
      regs.entry_mode_byte      <= lcdw_pkg::RST_ENTRY_MODE;
    end else if (cfg_valid) begin
      case (cfg_index)
        lcdw_pkg::REG_PULSE_WIDTH:  regs.pulse_width_ms       <= cfg_data;
        lcdw_pkg::REG_SHORT_WAIT:   regs.short_wait_ms        <= cfg_data;
        lcdw_pkg::REG_LONG_WAIT:    regs.long_wait_ms         <= cfg_data;
        lcdw_pkg::REG_WAKEUP_WAIT:  regs.wakeup_wait_ms       <= cfg_data;
        lcdw_pkg::REG_FUNCTION_SET: regs.function_set_byte    <= cfg_data;
        lcdw_pkg::REG_SHIFT_SETUP:  regs.shift_setup_byte     <= cfg_data;
        lcdw_pkg::REG_DISPLAY_CTRL: regs.display_control_byte <= cfg_data;
        lcdw_pkg::REG_ENTRY_MODE:   regs.entry_mode_byte      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/lcdw_front.sv
module lcdw_front #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lcdw_pkg::in_item_t in_item,
  output logic               job_valid,
  output lcdw_pkg::job_t     job,
  input  logic               job_pop
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lcdw_pkg::job_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  lcdw_pkg::job_t   new_job;
  logic             push;
  logic             accept;
  logic             do_pop;

  // classify the request; unused command codes are dropped
  always_comb begin
    new_job.data        = in_item.byte_value;
    new_job.long_settle = (in_item.byte_value < lcdw_pkg::LONG_WAIT_LIMIT);
    push                = 1'b1;
    case (in_item.command)
      lcdw_pkg::CMD_INSTR: new_job.kind = lcdw_pkg::JOB_INSTR;
      lcdw_pkg::CMD_CHAR:  new_job.kind = lcdw_pkg::JOB_CHAR;
      lcdw_pkg::CMD_INIT:  new_job.kind = lcdw_pkg::JOB_INIT;
      default: begin
        new_job.kind = lcdw_pkg::JOB_INSTR;
        push         = 1'b0;
      end
    endcase
  end

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign accept    = in_valid && in_ready && push;
  assign job_valid = (count != '0);
  assign job       = entries[rd_ptr];
  assign do_pop    = job_pop && job_valid;

  always_ff @(posedge clk) begin
    if (accept) begin
      entries[wr_ptr] <= new_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (accept && !do_pop) begin
        count <= count + 1'b1;
      end else if (!accept && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/lcdw_back.sv
module lcdw_back (
  input  logic                clk,
  input  logic                rst,
  input  lcdw_pkg::cfg_t      regs,
  input  logic                job_valid,
  input  lcdw_pkg::job_t      job,
  output logic                job_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output lcdw_pkg::out_item_t out_item
);

  typedef enum logic [1:0] {
    PH_WAKE  = 2'b01,
    PH_BYTES = 2'b10
  } phase_t;

  phase_t              phase;
  logic [3:0]          wake_step;
  logic [2:0]          nib_step;
  logic [1:0]          byte_sel;
  logic                fire;
  logic                in_wake;
  logic [7:0]          cur_byte;
  logic                cur_rs;
  logic [7:0]          settle;
  lcdw_pkg::out_item_t seg;

  assign fire    = job_valid && (!out_valid || out_ready);
  assign in_wake = (job.kind == lcdw_pkg::JOB_INIT) && (phase == PH_WAKE);

  // byte being sent and its settle time
  always_comb begin
    cur_byte = job.data;
    cur_rs   = 1'b0;
    settle   = job.long_settle ? regs.long_wait_ms : regs.short_wait_ms;
    case (job.kind)
      lcdw_pkg::JOB_CHAR: begin
        cur_rs = 1'b1;
        settle = '0;
      end
      lcdw_pkg::JOB_INIT: begin
        case (byte_sel)
          2'd0:    cur_byte = regs.function_set_byte;
          2'd1:    cur_byte = regs.shift_setup_byte;
          2'd2:    cur_byte = regs.display_control_byte;
          default: cur_byte = regs.entry_mode_byte;
        endcase
        settle = (cur_byte < lcdw_pkg::LONG_WAIT_LIMIT) ? regs.long_wait_ms
                                                         : regs.short_wait_ms;
      end
      default: ;
    endcase
  end

  always_comb begin
    seg.read_write      = 1'b0;
    seg.register_select = cur_rs;
    seg.enable_pin      = 1'b0;
    seg.bus_nibble      = cur_byte[3:0];
    seg.hold_ms         = '0;
    seg.last_segment    = 1'b0;
    if (in_wake) begin
      seg.register_select = 1'b0;
      case (wake_step)
        4'd0: seg.bus_nibble = '0;
        4'd1: begin
          seg.bus_nibble = lcdw_pkg::WAKE_NIBBLE;
          seg.hold_ms    = regs.wakeup_wait_ms;
        end
        4'd2, 4'd4, 4'd6: begin
          seg.enable_pin = 1'b1;
          seg.bus_nibble = lcdw_pkg::WAKE_NIBBLE;
          seg.hold_ms    = regs.pulse_width_ms;
        end
        4'd3, 4'd5, 4'd7: begin
          seg.bus_nibble = lcdw_pkg::WAKE_NIBBLE;
          seg.hold_ms    = regs.short_wait_ms;
        end
        4'd8: begin
          seg.bus_nibble = lcdw_pkg::MODE_NIBBLE;
          seg.hold_ms    = regs.wakeup_wait_ms;
        end
        4'd9: begin
          seg.enable_pin = 1'b1;
          seg.bus_nibble = lcdw_pkg::MODE_NIBBLE;
          seg.hold_ms    = regs.pulse_width_ms;
        end
        default: seg.bus_nibble = lcdw_pkg::MODE_NIBBLE;
      endcase
    end else begin
      case (nib_step)
        3'd0: seg.bus_nibble = cur_byte[7:4];
        3'd1: begin
          seg.enable_pin = 1'b1;
          seg.bus_nibble = cur_byte[7:4];
          seg.hold_ms    = regs.pulse_width_ms;
        end
        3'd2: ;
        3'd3: begin
          seg.enable_pin = 1'b1;
          seg.hold_ms    = regs.pulse_width_ms;
        end
        default: begin
          seg.hold_ms      = settle;
          seg.last_segment = (job.kind != lcdw_pkg::JOB_INIT) ||
                             (byte_sel == lcdw_pkg::INIT_BYTE_LAST);
        end
      endcase
    end
  end

  assign job_pop = fire && seg.last_segment;

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= seg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= PH_WAKE;
      wake_step <= '0;
      nib_step  <= '0;
      byte_sel  <= '0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (fire) begin
        if (seg.last_segment) begin
          phase     <= PH_WAKE;
          wake_step <= '0;
          nib_step  <= '0;
          byte_sel  <= '0;
        end else if (in_wake) begin
          if (wake_step == lcdw_pkg::WAKE_LAST) begin
            phase     <= PH_BYTES;
            wake_step <= '0;
          end else begin
            wake_step <= wake_step + 1'b1;
          end
        end else if (nib_step == lcdw_pkg::NIB_LAST) begin
          nib_step <= '0;
          byte_sel <= byte_sel + 1'b1;
        end else begin
          nib_step <= nib_step + 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/char_lcd_nibble_write_sequencer_unit.sv
// character lcd write sequencer for a 4-bit bus
// in channel: one item is a request (send instruction, send character, initialize);
//   unused command codes are taken and produce nothing
// out channel: one item per pin segment (enable, rs, rw, nibble, hold time in ms),
//   last_segment marks the end of a request
// a byte request gives 5 segments, initialize gives 31; one segment leaves per cycle
//   while out_ready is high and a job is queued, as set by the
//   one-segment-per-cycle back sequencer
// a taken request is written into the queue, and its first segment then goes
//   through the output register before out_valid shows it
// requests wait in a small queue, so new ones are taken while a job runs
// when the receiver stalls, the output register holds its segment and the
//   sequencer waits; the queue keeps taking requests until it fills
// cfg channel: always ready, index 0..7 selects a register, higher indexes ignored
// reset: queue empty, no output valid, timing and setup registers to defaults
module char_lcd_nibble_write_sequencer_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lcdw_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lcdw_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lcdw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                          cfg_data
);

  lcdw_pkg::cfg_t regs;
  lcdw_pkg::job_t job;
  logic           job_valid;
  logic           job_pop;

  // timing and setup registers
  lcdw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // front: classify requests and queue them
  lcdw_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  // back: walk the head job segment by segment into the output register
  lcdw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
